// ===== design/rld_pkg.sv =====
// ----------------------------------------------------------------------------
// rld_pkg
// shared types, constants and helpers of the uart run length decoder
// ----------------------------------------------------------------------------
`default_nettype none

package rld_pkg;

    localparam int DURATION_WIDTH = 15;
    localparam int MBT_W          = 15;
    localparam int DBITS_W        = 4;
    localparam int SBITS_W        = 2;
    localparam int PMODE_W        = 2;
    localparam int CFG_DATA_W     = 15;
    localparam int CFG_ADDR_W     = 2;
    localparam int CNT_W          = 9;
    localparam int NBITS_W        = 8;
    localparam int FLEN_W         = 5;
    localparam int FRAME_W        = 16;
    localparam int BYTE_W         = 8;
    localparam int DIV_CNT_W      = $clog2(DURATION_WIDTH);
    localparam int CMP_W          = (DURATION_WIDTH > MBT_W) ? DURATION_WIDTH : MBT_W;

    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_BIT_TIME = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHAR_LEN     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_STOP_LEN     = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PARITY_MODE  = 2'd3;

    localparam logic [MBT_W-1:0]   RST_MIN_BIT_TIME = 15'd72;
    localparam logic [DBITS_W-1:0] RST_CHAR_LEN     = 4'd8;
    localparam logic [SBITS_W-1:0] RST_STOP_LEN     = 2'd1;
    localparam logic [PMODE_W-1:0] RST_PARITY_MODE  = 2'd0;

    localparam logic [PMODE_W-1:0] PAR_NONE = 2'd0;
    localparam logic [PMODE_W-1:0] PAR_EVEN = 2'd1;
    localparam logic [PMODE_W-1:0] PAR_ODD  = 2'd2;

    typedef struct packed {
        logic [MBT_W-1:0]   min_bit_time;
        logic [DBITS_W-1:0] char_len;
        logic [SBITS_W-1:0] stop_len;
        logic [PMODE_W-1:0] parity_mode;
    } t_cfg;

    typedef struct packed {
        logic                      first;
        logic                      level;
        logic                      is_zero;
        logic                      is_short;
        logic [DURATION_WIDTH-1:0] ticks;
    } t_run;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic idle;
        logic apply;
    } t_back_stat;

    function automatic logic [MBT_W-1:0] eff_min_bit(input logic [MBT_W-1:0] m);
        eff_min_bit = (m == '0) ? MBT_W'(1) : m;
    endfunction

endpackage

`default_nettype wire

// ===== design/rld_run_if.sv =====
// ----------------------------------------------------------------------------
// rld_run_if
// line run channel: one item is one run of the line
// ----------------------------------------------------------------------------
`default_nettype none

interface rld_run_if
    import rld_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic                      first_in_chunk;
    logic                      line_level;
    logic [DURATION_WIDTH-1:0] run_ticks;

    modport source (output valid, output first_in_chunk, output line_level,
                    output run_ticks, input ready);
    modport sink   (input valid, input first_in_chunk, input line_level,
                    input run_ticks, output ready);
endinterface

`default_nettype wire

// ===== design/rld_byte_if.sv =====
// ----------------------------------------------------------------------------
// rld_byte_if
// received byte channel: one item is one completed frame
// ----------------------------------------------------------------------------
`default_nettype none

interface rld_byte_if
    import rld_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_data;
    logic              parity_error;

    modport source (output valid, output rx_data, output parity_error, input ready);
    modport sink   (input valid, input rx_data, input parity_error, output ready);
endinterface

`default_nettype wire

// ===== design/rld_front.sv =====
// ----------------------------------------------------------------------------
// rld_front
// input stage: registers a run and classifies it as zero length or short
// ----------------------------------------------------------------------------
`default_nettype none

module rld_front
    import rld_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cfg   i_cfg,
    rld_run_if.sink     i_run,
    input  wire logic   i_q_ready,
    output logic        o_push,
    output t_run        o_item
);

    logic r_valid;
    t_run r_item;
    logic [MBT_W-1:0] minb;
    logic take;

    assign minb        = eff_min_bit(i_cfg.min_bit_time);
    assign i_run.ready = !r_valid || i_q_ready;
    assign take        = i_run.valid && i_run.ready;
    assign o_push      = r_valid && i_q_ready;
    assign o_item      = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.first    <= i_run.first_in_chunk;
            r_item.level    <= i_run.line_level;
            r_item.is_zero  <= (i_run.run_ticks == '0);
            r_item.is_short <= (CMP_W'(i_run.run_ticks) < CMP_W'(minb));
            r_item.ticks    <= i_run.run_ticks;
        end
    end

endmodule

`default_nettype wire

// ===== design/rld_queue.sv =====
// ----------------------------------------------------------------------------
// rld_queue
// two entry queue of classified runs between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module rld_queue
    import rld_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_run i_item,
    input  wire logic i_pop,
    output t_run      o_item,
    output t_q_stat   o_stat
);

    t_run       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_item       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== design/rld_back.sv =====
// ----------------------------------------------------------------------------
// rld_back
// frame builder: divides the run by the bit time, fills the frame, checks parity
// ----------------------------------------------------------------------------
`default_nettype none

module rld_back
    import rld_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cfg   i_cfg,
    input  wire t_run   i_item,
    input  wire logic   i_q_empty,
    output logic        o_pop,
    output t_back_stat  o_stat,
    rld_byte_if.source  o_byte
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DURATION_WIDTH - 1);

    logic [1:0]                r_state;
    t_run                      r_item;
    logic [MBT_W-1:0]          r_rem;
    logic [DURATION_WIDTH-1:0] r_quo;
    logic [DIV_CNT_W-1:0]      r_cnt;
    logic [FRAME_W-1:0]        r_frame;
    logic [CNT_W-1:0]          r_bit_count;
    logic                      r_out_valid;
    logic [BYTE_W-1:0]         r_data;
    logic                      r_perr;

    logic [MBT_W-1:0]   minb;
    logic [MBT_W:0]     trial;
    logic               ge;
    logic [MBT_W-1:0]   n_rem;
    logic [CNT_W-1:0]   eff_cnt;
    logic [FRAME_W-1:0] eff_frame;
    logic               skip;
    logic [FLEN_W-1:0]  flen;
    logic [CNT_W-1:0]   gap;
    logic [NBITS_W-1:0] nbits;
    logic [CNT_W:0]     bit_end;
    logic [FRAME_W-1:0] set_mask;
    logic [FRAME_W-1:0] n_frame;
    logic [CNT_W-1:0]   n_bit_count;
    logic               done;
    logic [BYTE_W-1:0]  data;
    logic [FLEN_W-1:0]  pidx;
    logic               pbit;
    logic               calc;
    logic               perr;
    logic               out_free;

    assign minb   = eff_min_bit(i_cfg.min_bit_time);
    assign trial  = {r_rem, r_quo[DURATION_WIDTH-1]};
    assign ge     = (trial >= {1'b0, minb});
    assign n_rem  = ge ? MBT_W'(trial - {1'b0, minb}) : MBT_W'(trial);

    assign eff_cnt   = r_item.first ? '0 : r_bit_count;
    assign eff_frame = r_item.first ? '0 : r_frame;
    assign skip      = (eff_cnt == '0) && (r_item.level || r_item.is_short);
    assign flen      = FLEN_W'(1) + FLEN_W'(i_cfg.char_len) + FLEN_W'(i_cfg.stop_len)
                       + ((i_cfg.parity_mode != PAR_NONE) ? FLEN_W'(1) : FLEN_W'(0));
    assign gap       = CNT_W'(flen) - eff_cnt;
    assign nbits     = r_item.is_zero ? gap[NBITS_W-1:0] : r_quo[NBITS_W-1:0];
    assign bit_end   = (CNT_W+1)'(eff_cnt) + (CNT_W+1)'(nbits);

    always_comb begin
        for (int p = 0; p < FRAME_W; p++) begin
            set_mask[p] = r_item.level && ((CNT_W+1)'(p) >= (CNT_W+1)'(eff_cnt))
                          && ((CNT_W+1)'(p) < bit_end);
        end
    end

    assign n_frame     = eff_frame | set_mask;
    assign n_bit_count = bit_end[CNT_W-1:0];
    assign done        = (n_bit_count >= CNT_W'(flen));

    always_comb begin
        for (int i = 0; i < BYTE_W; i++) begin
            data[i] = (DBITS_W'(i) < i_cfg.char_len) ? n_frame[i+1] : 1'b0;
        end
    end

    assign pidx = FLEN_W'(i_cfg.char_len) + FLEN_W'(1);
    assign pbit = (pidx < FLEN_W'(FRAME_W)) ? n_frame[pidx[3:0]] : 1'b0;
    assign calc = ^data;
    assign perr = ((i_cfg.parity_mode == PAR_EVEN) && (calc != pbit))
               || ((i_cfg.parity_mode == PAR_ODD) && (calc == pbit));

    assign out_free = !r_out_valid || o_byte.ready;
    assign o_pop    = (r_state == ST_IDLE) && !i_q_empty;

    assign o_stat.idle  = (r_state == ST_IDLE);
    assign o_stat.apply = (r_state == ST_APPLY);

    assign o_byte.valid        = r_out_valid;
    assign o_byte.rx_data      = r_data;
    assign o_byte.parity_error = r_perr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bit_count <= '0;
            r_frame     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == ST_APPLY) && !skip && done && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_byte.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_cnt == DIV_LAST) begin
                        r_state <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    if (skip) begin
                        r_bit_count <= eff_cnt;
                        r_frame     <= eff_frame;
                        r_state     <= ST_IDLE;
                    end else if (!done) begin
                        r_bit_count <= n_bit_count;
                        r_frame     <= n_frame;
                        r_state     <= ST_IDLE;
                    end else if (out_free) begin
                        r_bit_count <= '0;
                        r_frame     <= '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
            r_quo  <= i_item.ticks;
            r_rem  <= '0;
            r_cnt  <= '0;
        end else if (r_state == ST_DIV) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DURATION_WIDTH-2:0], ge};
            r_cnt <= r_cnt + DIV_CNT_W'(1);
        end
        if ((r_state == ST_APPLY) && !skip && done && out_free) begin
            r_data <= data;
            r_perr <= perr;
        end
    end

endmodule

`default_nettype wire

// ===== design/uart_run_length_decoder.sv =====
// ----------------------------------------------------------------------------
// uart_run_length_decoder
// rebuilds uart frames from line runs and emits data bytes with parity status
// ----------------------------------------------------------------------------
//  channel   dir   handshake           payload
//  i_run     in    valid / ready       first_in_chunk, line_level, run_ticks
//  o_byte    out   valid / ready       rx_data, parity_error
//  i_cfg_*   in    write enable only   i_cfg_addr, i_cfg_wdata
//
//  each run passes through the frame builder in order: load, bit-serial restoring
//  division of run_ticks by min_bit_time, then apply; the next run loads after apply
//  a two-entry queue behind the input register lets runs arrive while one is divided
//  a finished byte waits in the output register; the builder stalls only when a
//  second frame completes before the first byte is taken
//  synchronous active-low reset loads the default configuration, clears partial frame and queues
// ----------------------------------------------------------------------------
`default_nettype none

module uart_run_length_decoder
    import rld_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    rld_run_if.sink                    i_run,
    rld_byte_if.source                 o_byte
);

    t_cfg       r_cfg;
    logic       q_push;
    t_run       front_item;
    t_run       q_item;
    t_q_stat    q_stat;
    logic       q_pop;
    t_back_stat back_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_bit_time <= RST_MIN_BIT_TIME;
            r_cfg.char_len     <= RST_CHAR_LEN;
            r_cfg.stop_len     <= RST_STOP_LEN;
            r_cfg.parity_mode  <= RST_PARITY_MODE;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MIN_BIT_TIME: r_cfg.min_bit_time <= MBT_W'(i_cfg_wdata);
                CFG_CHAR_LEN:     r_cfg.char_len     <= i_cfg_wdata[DBITS_W-1:0];
                CFG_STOP_LEN:     r_cfg.stop_len     <= i_cfg_wdata[SBITS_W-1:0];
                CFG_PARITY_MODE:  r_cfg.parity_mode  <= i_cfg_wdata[PMODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    rld_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_run     (i_run),
        .i_q_ready (!q_stat.full),
        .o_push    (q_push),
        .o_item    (front_item)
    );

    rld_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    rld_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_item    (q_item),
        .i_q_empty (q_stat.empty),
        .o_pop     (q_pop),
        .o_stat    (back_stat),
        .o_byte    (o_byte)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |-> !(q_push && !q_pop))
        else $error("run pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.empty |-> !q_pop)
        else $error("run popped from empty queue");

    a_byte_from_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_byte.valid) |-> $past(back_stat.apply))
        else $error("byte item raised outside apply step");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> back_stat.idle)
        else $error("frame builder took a run while busy");

endmodule

`default_nettype wire
